// ----- rtl/rbida_pkg.sv -----
// Shared types and constants for the refcounted bitmap slot allocator.
// No dependencies; every other file but rbida_ram refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package rbida_pkg;

  localparam int SLOT_W           = 10;
  localparam int LIVE_W           = 11;
  localparam int CNT_OUT_W        = 16;
  localparam int CFG_W            = 6;
  localparam int PAGE_SLOTS       = 32;
  localparam int SLOT_LIMIT_PAGES = 32;
  localparam logic [PAGE_SLOTS-1:0] PAGE_ALL_SET = 32'hFFFF_FFFF;
  localparam logic [CFG_W-1:0]      ACTIVE_PAGES_RESET = 6'd32;

  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_ACQUIRE = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_UNUSED  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_NOFREE = 3'd1,
    ST_RANGE  = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_SAT    = 3'd4
  } status_t;

  // Class decided by the front end: range errors never reach the bitmap.
  typedef enum logic [1:0] {
    CL_ALLOC,
    CL_ACQUIRE,
    CL_RELEASE,
    CL_RANGE
  } cls_t;

  typedef struct packed {
    cls_t              cls;
    logic [SLOT_W-1:0] slot_id;
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/rbida_if.sv -----
// Valid/ready channel interfaces: request, result and configuration write.
// Depends on rbida_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface rbida_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                kind;
  logic [rbida_pkg::SLOT_W-1:0] slot_id;

  modport source (output valid, output kind, output slot_id, input ready);
  modport sink   (input valid, input kind, input slot_id, output ready);
endinterface

interface rbida_out_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    status;
  logic [rbida_pkg::SLOT_W-1:0]    result_slot;
  logic [rbida_pkg::CNT_OUT_W-1:0] ref_count;
  logic                          freed;
  logic [rbida_pkg::LIVE_W-1:0]    live_slots;

  modport source (output valid, output status, output result_slot, output ref_count,
                  output freed, output live_slots, input ready);
  modport sink   (input valid, input status, input result_slot, input ref_count,
                  input freed, input live_slots, output ready);
endinterface

interface rbida_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [rbida_pkg::CFG_W-1:0] active_pages;

  modport source (output valid, output active_pages, input ready);
  modport sink   (input valid, input active_pages, output ready);
endinterface

`default_nettype wire

// ----- rtl/rbida_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rbida_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rbida_front.sv -----
// Front end: accepts request words, classifies them against the page limit
// and hands them to the command queue. Depends on rbida_pkg, rbida_if.
`timescale 1ns / 1ps
`default_nettype none

module rbida_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  rbida_in_if.sink                         in_if,
  input  wire logic [rbida_pkg::CFG_W-1:0] npages,
  output logic                             push_valid,
  input  wire logic                        push_ready,
  output rbida_pkg::cmd_t                  push_data
);

  logic            stage_valid_r;
  rbida_pkg::cmd_t stage_r;
  rbida_pkg::cmd_t cls_nxt;
  logic            in_take;

  assign in_if.ready = !stage_valid_r || push_ready;
  assign in_take     = in_if.valid && in_if.ready;
  assign push_valid  = stage_valid_r;
  assign push_data   = stage_r;

  always_comb begin
    cls_nxt.slot_id = in_if.slot_id;
    unique case (rbida_pkg::kind_t'(in_if.kind))
      rbida_pkg::KIND_ALLOC:   cls_nxt.cls = rbida_pkg::CL_ALLOC;
      rbida_pkg::KIND_ACQUIRE: cls_nxt.cls = rbida_pkg::CL_ACQUIRE;
      rbida_pkg::KIND_RELEASE: cls_nxt.cls = rbida_pkg::CL_RELEASE;
      default:                 cls_nxt.cls = rbida_pkg::CL_RANGE;
    endcase
    // slot beyond the active pages: page number compared against the limit
    if (cls_nxt.cls != rbida_pkg::CL_ALLOC &&
        {1'b0, in_if.slot_id[rbida_pkg::SLOT_W-1:5]} >= npages) begin
      cls_nxt.cls = rbida_pkg::CL_RANGE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_take) begin
      stage_valid_r <= 1'b1;
    end else if (push_ready) begin
      stage_valid_r <= 1'b0;
    end
    if (in_take) begin
      stage_r <= cls_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rbida_fifo.sv -----
// Short command queue between front end and back end.
// Depends on rbida_pkg for the command word type.
`timescale 1ns / 1ps
`default_nettype none

module rbida_fifo #(
  parameter int DEPTH = 2
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire rbida_pkg::cmd_t push_data,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output rbida_pkg::cmd_t      pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rbida_pkg::cmd_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push;
  logic             pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rbida_back.sv -----
// Back end: page bitmap, full flags, live count and the refcount RAM
// sequencer that executes one queued command at a time and registers the
// result word. Depends on rbida_pkg, rbida_if, rbida_ram.
`timescale 1ns / 1ps
`default_nettype none

module rbida_back #(
  parameter int NPG         = 32,
  parameter int PW          = 5,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        pop_valid,
  output logic                             pop_ready,
  input  wire rbida_pkg::cmd_t             pop_data,
  input  wire logic [rbida_pkg::CFG_W-1:0] npages,
  rbida_out_if.source                      out_if
);

  localparam int AW    = PW + 5;
  localparam int DEPTH = NPG * rbida_pkg::PAGE_SLOTS;
  localparam logic [COUNT_WIDTH-1:0] CNT_TOP = '1;
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

  typedef enum logic [1:0] {S_IDLE, S_FIND, S_EXEC} state_t;

  state_t                            st_r;
  rbida_pkg::cmd_t                   cmd_r;
  logic [PW-1:0]                     page_r;
  logic                              found_r;
  logic                              occ_r;
  logic [rbida_pkg::PAGE_SLOTS-1:0]  bitmap_r [NPG];
  logic [NPG-1:0]                    full_r;
  logic [rbida_pkg::LIVE_W-1:0]      live_r;
  logic                              out_valid_r;
  rbida_pkg::status_t                out_status_r;
  logic [rbida_pkg::SLOT_W-1:0]      out_slot_r;
  logic [rbida_pkg::CNT_OUT_W-1:0]   out_cnt_r;
  logic                              out_freed_r;

  logic [PW-1:0]                     sid_page;
  logic [4:0]                        sid_bit;
  logic [NPG-1:0]                    cand;
  logic [PW-1:0]                     free_page;
  logic [rbida_pkg::PAGE_SLOTS-1:0]  word;
  logic [rbida_pkg::PAGE_SLOTS-1:0]  word_set;
  logic [4:0]                        free_bit;
  logic [COUNT_WIDTH-1:0]            rdata;
  logic                              re;
  logic                              exec_go;
  logic                              we;
  logic [AW-1:0]                     waddr;
  logic [COUNT_WIDTH-1:0]            wdata;
  logic                              set_bit;
  logic                              clr_bit;
  rbida_pkg::status_t                res_status;
  logic [rbida_pkg::SLOT_W-1:0]      res_slot;
  logic [COUNT_WIDTH-1:0]            res_cnt;
  logic [31:0]                       res_cnt_w;
  logic                              res_freed;

  assign sid_page  = cmd_r.slot_id[PW+4:5];
  assign sid_bit   = cmd_r.slot_id[4:0];
  assign pop_ready = (st_r == S_IDLE);
  assign re        = pop_valid && pop_ready;
  assign exec_go   = (st_r == S_EXEC) && (!out_valid_r || out_if.ready);

  // first page that is not full among the active ones
  always_comb begin
    free_page = '0;
    for (int p = NPG - 1; p >= 0; p--) begin
      cand[p] = !full_r[p] && (npages > rbida_pkg::CFG_W'(p));
      if (cand[p]) begin
        free_page = PW'(p);
      end
    end
  end

  // lowest clear bit of the chosen page
  always_comb begin
    word     = bitmap_r[page_r];
    free_bit = '0;
    for (int b = rbida_pkg::PAGE_SLOTS - 1; b >= 0; b--) begin
      if (!word[b]) begin
        free_bit = 5'(b);
      end
    end
    word_set = word | (32'd1 << free_bit);
  end

  always_comb begin
    we         = 1'b0;
    waddr      = cmd_r.slot_id[AW-1:0];
    wdata      = '0;
    set_bit    = 1'b0;
    clr_bit    = 1'b0;
    res_status = rbida_pkg::ST_OK;
    res_slot   = cmd_r.slot_id;
    res_cnt    = '0;
    res_freed  = 1'b0;
    case (cmd_r.cls)
      rbida_pkg::CL_ALLOC: begin
        if (!found_r) begin
          res_status = rbida_pkg::ST_NOFREE;
          res_slot   = '0;
        end else begin
          we       = 1'b1;
          waddr    = {page_r, free_bit};
          wdata    = CNT_ONE;
          set_bit  = 1'b1;
          res_slot = rbida_pkg::SLOT_W'({page_r, free_bit});
          res_cnt  = CNT_ONE;
        end
      end
      rbida_pkg::CL_ACQUIRE: begin
        if (!occ_r) begin
          res_status = rbida_pkg::ST_EMPTY;
        end else if (rdata == CNT_TOP) begin
          res_status = rbida_pkg::ST_SAT;
          res_cnt    = CNT_TOP;
        end else begin
          we      = 1'b1;
          wdata   = rdata + 1'b1;
          res_cnt = rdata + 1'b1;
        end
      end
      rbida_pkg::CL_RELEASE: begin
        if (!occ_r) begin
          res_status = rbida_pkg::ST_EMPTY;
        end else if (rdata > CNT_ONE) begin
          we      = 1'b1;
          wdata   = rdata - 1'b1;
          res_cnt = rdata - 1'b1;
        end else begin
          we        = 1'b1;
          clr_bit   = 1'b1;
          res_freed = 1'b1;
        end
      end
      default: begin
        res_status = rbida_pkg::ST_RANGE;
      end
    endcase
    res_cnt_w = 32'(res_cnt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
      live_r      <= '0;
      full_r      <= '0;
      for (int p = 0; p < NPG; p++) begin
        bitmap_r[p] <= '0;
      end
    end else begin
      // drop a taken word unless the next one replaces it on this edge
      if (out_valid_r && out_if.ready && !exec_go) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        S_IDLE: begin
          if (pop_valid) begin
            st_r <= S_FIND;
          end
        end
        S_FIND: begin
          st_r <= S_EXEC;
        end
        S_EXEC: begin
          if (exec_go) begin
            st_r         <= S_IDLE;
            out_valid_r  <= 1'b1;
            out_status_r <= res_status;
            out_slot_r   <= res_slot;
            out_cnt_r    <= res_cnt_w[rbida_pkg::CNT_OUT_W-1:0];
            out_freed_r  <= res_freed;
            if (set_bit) begin
              bitmap_r[page_r] <= word_set;
              full_r[page_r]   <= (word_set == rbida_pkg::PAGE_ALL_SET);
              live_r           <= live_r + 1'b1;
            end
            if (clr_bit) begin
              bitmap_r[sid_page][sid_bit] <= 1'b0;
              full_r[sid_page]            <= 1'b0;
              if (live_r != '0) begin
                live_r <= live_r - 1'b1;
              end
            end
          end
        end
        default: begin
          st_r <= S_IDLE;
        end
      endcase
    end
    if (re) begin
      cmd_r <= pop_data;
    end
    if (st_r == S_FIND) begin
      page_r  <= (cmd_r.cls == rbida_pkg::CL_ALLOC) ? free_page : sid_page;
      found_r <= |cand;
      occ_r   <= bitmap_r[sid_page][sid_bit];
    end
  end

  rbida_ram #(
    .WIDTH  (COUNT_WIDTH),
    .DEPTH  (DEPTH),
    .ADDR_W (AW)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (exec_go && we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (pop_data.slot_id[AW-1:0]),
    .rdata (rdata)
  );

  assign out_if.valid       = out_valid_r;
  assign out_if.status      = out_status_r;
  assign out_if.result_slot = out_slot_r;
  assign out_if.ref_count   = out_cnt_r;
  assign out_if.freed       = out_freed_r;
  assign out_if.live_slots  = live_r;

endmodule

`default_nettype wire

// ----- rtl/refcounted_bitmap_id_allocator.sv -----
// A request passes the front-end stage register and the command queue, then
// the back-end states S_IDLE (queue pop with refcount RAM read), S_FIND
// (page search) and S_EXEC (read-modify-write), which registers the result.
// The sequencer takes no new request until S_EXEC has registered the last.
// Reset (rst_n low, synchronous): bitmap, full flags and live count clear,
// active_pages returns to 32; the refcount RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module refcounted_bitmap_id_allocator #(
  parameter int MAX_PAGES   = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  rbida_in_if.sink    in_if,
  rbida_out_if.source out_if,
  rbida_cfg_if.sink   cfg_if
);

  // slot ids are 10 bits wide, so never more than 32 pages are reachable
  localparam int NPG = (MAX_PAGES < rbida_pkg::SLOT_LIMIT_PAGES) ?
                       MAX_PAGES : rbida_pkg::SLOT_LIMIT_PAGES;
  localparam int PW  = (NPG > 1) ? $clog2(NPG) : 1;

  logic [rbida_pkg::CFG_W-1:0] active_pages_r;
  logic [rbida_pkg::CFG_W-1:0] npages;
  logic                        push_valid;
  logic                        push_ready;
  rbida_pkg::cmd_t             push_data;
  logic                        pop_valid;
  logic                        pop_ready;
  rbida_pkg::cmd_t             pop_data;

  assign cfg_if.ready = 1'b1;
  assign npages = (active_pages_r > rbida_pkg::CFG_W'(NPG)) ?
                  rbida_pkg::CFG_W'(NPG) : active_pages_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_pages_r <= rbida_pkg::ACTIVE_PAGES_RESET;
    end else if (cfg_if.valid) begin
      active_pages_r <= cfg_if.active_pages;
    end
  end

  rbida_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .npages     (npages),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  rbida_fifo #(
    .DEPTH (2)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  rbida_back #(
    .NPG         (NPG),
    .PW          (PW),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .npages    (npages),
    .out_if    (out_if)
  );

endmodule

`default_nettype wire

// ----- rtl/rbida_checker.sv -----
// Port-level checks on the allocator result channel, bound to the top level.
// Depends on rbida_pkg for status codes and widths.
`timescale 1ns / 1ps
`default_nettype none

module rbida_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [2:0]                      status,
  input wire logic [rbida_pkg::SLOT_W-1:0]    result_slot,
  input wire logic [rbida_pkg::CNT_OUT_W-1:0] ref_count,
  input wire logic                            freed,
  input wire logic [rbida_pkg::LIVE_W-1:0]    live_slots
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
    $stable(result_slot) && $stable(ref_count) && $stable(freed) &&
    $stable(live_slots))
    else $error("result word changed while stalled");

  // a freed slot reports ok with a zero count
  a_freed_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && freed |-> status == rbida_pkg::ST_OK && ref_count == '0)
    else $error("freed flag on a result that is not a clean release");

  // error words carry no count and never free
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == rbida_pkg::ST_NOFREE || status == rbida_pkg::ST_RANGE ||
                  status == rbida_pkg::ST_EMPTY) |-> ref_count == '0 && !freed)
    else $error("error result with nonzero count or freed flag");

  // live count never exceeds the slot space and status is a known code
  a_live_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> live_slots <= rbida_pkg::LIVE_W'(1024) &&
                  (status == rbida_pkg::ST_OK || status == rbida_pkg::ST_NOFREE ||
                   status == rbida_pkg::ST_RANGE || status == rbida_pkg::ST_EMPTY ||
                   status == rbida_pkg::ST_SAT))
    else $error("live count or status out of range");

endmodule

bind refcounted_bitmap_id_allocator rbida_checker u_rbida_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .status      (out_if.status),
  .result_slot (out_if.result_slot),
  .ref_count   (out_if.ref_count),
  .freed       (out_if.freed),
  .live_slots  (out_if.live_slots)
);

`default_nettype wire
